>>> rtl/slir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slir_pkg: shared types and constants of the sorted list
// Store geometry, request and status codes, and the structs that pass
// between the sequencer, the store and the output register.
// ----------------------------------------------------------------------------
package slir_pkg;

  localparam int CAPACITY = 16;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int DW       = 32;

  typedef logic signed [DW-1:0] data_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    data_t         wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic    valid;
    data_t   item;
    logic    last;
    logic    empty;
    status_e status;
  } res_t;

  typedef struct packed {
    logic          busy;
    logic [CW-1:0] count;
  } ctrl_stat_t;

endpackage

>>> rtl/sorted_list_insert_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove: bounded sorted list with insert and remove
// Keeps up to 16 signed values in ascending order and lists them after
// every request.
// ----------------------------------------------------------------------------
// One request is taken at a time. An insert scans the memory downward from
// the last entry, moving larger entries up one place per cycle; a remove
// scans upward, finds the first equal entry and moves the rest down. Both
// scans go through the single read port of the entry memory; the list is
// then read out at one item per cycle while the consumer does not stall,
// and the next request is taken once the last item has gone to the output
// register. An insert into a full list is dropped with status full, a
// remove of an absent value leaves the list with status not found, and an
// empty list gives a single item flagged is_empty with value zero.
module sorted_list_insert_remove import slir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] item_value_o,
  output logic        is_last_o,
  output logic        is_empty_o,
  output logic [1:0]  status_o
);

  mem_req_t   mem_req;
  data_t      rdata;
  res_t       res;
  ctrl_stat_t stat;
  logic       out_free;

  slir_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  slir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .value_i    (data_t'(value_i)),
    .rdata_i    (rdata),
    .out_free_i (out_free),
    .mem_req_o  (mem_req),
    .res_o      (res),
    .stat_o     (stat)
  );

  slir_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res),
    .free_o       (out_free),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .item_value_o (item_value_o),
    .is_last_o    (is_last_o),
    .is_empty_o   (is_empty_o),
    .status_o     (status_o)
  );

  assign in_stall_o = stat.busy;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (stat.count == $past(stat.count)) ||
             (stat.count == CW'($past(stat.count) + 1'b1)) ||
             (stat.count == CW'($past(stat.count) - 1'b1)))
    else $error("entry count moved by more than one");

  a_empty_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> is_last_o && (item_value_o == '0))
    else $error("empty item is not a single zero item");

  a_idle_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_INSERT) &&
    (stat.count == CW'(CAPACITY)) |=> stat.count == CW'(CAPACITY))
    else $error("insert into full list changed the count");

endmodule

>>> rtl/slir_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slir_store: entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slir_store import slir_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output data_t    rdata_o
);

  data_t mem_q [CAPACITY];
  data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/slir_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slir_ctrl: request sequencer
// Scans the store for the insert or remove position, shifts entries through
// the memory one per cycle, then reads the list out in ascending order.
// ----------------------------------------------------------------------------
module slir_ctrl import slir_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       req_type_i,
  input  data_t      value_i,
  input  data_t      rdata_i,
  input  logic       out_free_i,
  output mem_req_t   mem_req_o,
  output res_t       res_o,
  output ctrl_stat_t stat_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INS   = 6'b000010,
    S_PUT   = 6'b000100,
    S_REM   = 6'b001000,
    S_DUMP  = 6'b010000,
    S_EMPTY = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  data_t         v_q, v_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] ra_q, ra_d;
  logic          found_q, found_d;
  status_e       status_q, status_d;
  logic [CW-1:0] dk_q, dk_d;
  logic          pend_q, pend_d;
  logic          pend_last_q, pend_last_d;

  logic [CW-1:0] cnt_m1;
  logic          hit;
  logic          load;
  logic          issue;

  assign cnt_m1 = CW'(count_q - 1'b1);
  assign hit    = (rdata_i == v_q);
  assign load   = pend_q && out_free_i;
  assign issue  = (dk_q != count_q) && (!pend_q || load);

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    count_d     = count_q;
    ra_d        = ra_q;
    found_d     = found_q;
    status_d    = status_q;
    dk_d        = dk_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    mem_req_o   = '0;
    res_o       = '0;
    res_o.status = status_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          v_d      = value_i;
          status_d = ST_OK;
          dk_d     = '0;
          found_d  = 1'b0;
          if (req_e'(req_type_i) == REQ_INSERT) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DUMP;
            end else if (count_q == '0) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = '0;
              mem_req_o.wdata = value_i;
              count_d         = CW'(1);
              state_d         = S_DUMP;
            end else begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = cnt_m1[AW-1:0];
              ra_d            = cnt_m1[AW-1:0];
              state_d         = S_INS;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_EMPTY;
            end else begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = '0;
              ra_d            = '0;
              state_d         = S_REM;
            end
          end
        end
      end
      S_INS: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = AW'(ra_q + 1'b1);
        if (rdata_i > v_q) begin
          mem_req_o.wdata = rdata_i;
          if (ra_q == '0) begin
            state_d = S_PUT;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = AW'(ra_q - 1'b1);
            ra_d            = AW'(ra_q - 1'b1);
          end
        end else begin
          mem_req_o.wdata = v_q;
          count_d         = CW'(count_q + 1'b1);
          state_d         = S_DUMP;
        end
      end
      S_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = '0;
        mem_req_o.wdata = v_q;
        count_d         = CW'(count_q + 1'b1);
        state_d         = S_DUMP;
      end
      S_REM: begin
        if (found_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = AW'(ra_q - 1'b1);
          mem_req_o.wdata = rdata_i;
        end
        found_d = found_q || hit;
        if (ra_q == cnt_m1[AW-1:0]) begin
          if (found_q || hit) begin
            count_d = cnt_m1;
            state_d = (count_q == CW'(1)) ? S_EMPTY : S_DUMP;
          end else begin
            status_d = ST_NOT_FOUND;
            state_d  = S_DUMP;
          end
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = AW'(ra_q + 1'b1);
          ra_d            = AW'(ra_q + 1'b1);
        end
      end
      S_DUMP: begin
        res_o.valid = pend_q;
        res_o.item  = rdata_i;
        res_o.last  = pend_last_q;
        res_o.empty = 1'b0;
        if (issue) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = dk_q[AW-1:0];
          dk_d            = CW'(dk_q + 1'b1);
          pend_d          = 1'b1;
          pend_last_d     = (dk_q == cnt_m1);
        end else if (load) begin
          pend_d = 1'b0;
        end
        if ((dk_q == count_q) && !pend_q) begin
          state_d = S_IDLE;
        end
      end
      S_EMPTY: begin
        res_o.valid = 1'b1;
        res_o.item  = '0;
        res_o.last  = 1'b1;
        res_o.empty = 1'b1;
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      found_q     <= 1'b0;
      status_q    <= ST_OK;
      dk_q        <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      found_q     <= found_d;
      status_q    <= status_d;
      dk_q        <= dk_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q  <= v_d;
    ra_q <= ra_d;
  end

  assign stat_o.busy  = (state_q != S_IDLE);
  assign stat_o.count = count_q;

endmodule

>>> rtl/slir_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slir_out: result output register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module slir_out import slir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  res_t        res_i,
  output logic        free_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [31:0] item_value_o,
  output logic        is_last_o,
  output logic        is_empty_o,
  output logic [1:0]  status_o
);

  logic    valid_q, valid_d;
  data_t   item_q;
  logic    last_q;
  logic    empty_q;
  status_e status_q;
  logic    load;

  assign free_o = !valid_q || !out_stall_i;
  assign load   = res_i.valid && free_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q   <= res_i.item;
      last_q   <= res_i.last;
      empty_q  <= res_i.empty;
      status_q <= res_i.status;
    end
  end

  assign out_valid_o  = valid_q;
  assign item_value_o = item_q;
  assign is_last_o    = last_q;
  assign is_empty_o   = empty_q;
  assign status_o     = status_q;

endmodule

>>> verif/tb_sorted_list_insert_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_remove: self-checking bench of the sorted list
// Sends inserts and removes, keeps a shadow copy of the list, and checks every
// listed item against the predicted listing, under several idling patterns.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_remove;
  import slir_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 2 * CAPACITY + 10;
  localparam int HOLDOFF_LEN    = 300;

  typedef struct {
    data_t   value;
    logic    last;
    logic    empty;
    status_e status;
  } list_item_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        req_type_i  = 1'b0;
  logic [31:0] value_i     = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] item_value_o;
  logic        is_last_o;
  logic        is_empty_o;
  logic [1:0]  status_o;

  list_item_t expected_listing[$];
  list_item_t head_item;
  data_t      shadow_list[CAPACITY];
  int         shadow_count   = 0;
  int         snd_idle_pct   = 0;
  int         rcv_stall_pct  = 0;
  int         holdoff_cycles = 0;
  int         quiet_cycles   = 0;
  int         err_count      = 0;
  int         requests_sent  = 0;
  int         items_checked  = 0;
  int         peak_count     = 0;
  int         status_seen[4] = '{0, 0, 0, 0};

  always #2 clk_i = ~clk_i;

  sorted_list_insert_remove uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .item_value_o (item_value_o),
    .is_last_o    (is_last_o),
    .is_empty_o   (is_empty_o),
    .status_o     (status_o)
  );

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic predict_listing(req_e req, data_t val);
    status_e    st;
    int         pos;
    int         i;
    list_item_t it;
    st  = ST_OK;
    pos = 0;
    if (req == REQ_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        st = ST_FULL;
      end else begin
        while (pos < shadow_count && shadow_list[pos] < val) pos++;
        for (i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i - 1];
        shadow_list[pos] = val;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      st = ST_EMPTY;
    end else begin
      while (pos < shadow_count && shadow_list[pos] != val) pos++;
      if (pos >= shadow_count) begin
        st = ST_NOT_FOUND;
      end else begin
        for (i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
        shadow_count--;
      end
    end
    status_seen[int'(st)]++;
    if (shadow_count > peak_count) peak_count = shadow_count;
    if (shadow_count == 0) begin
      it.value  = '0;
      it.last   = 1'b1;
      it.empty  = 1'b1;
      it.status = st;
      expected_listing.push_back(it);
    end else begin
      for (i = 0; i < shadow_count; i++) begin
        it.value  = shadow_list[i];
        it.last   = (i == shadow_count - 1);
        it.empty  = 1'b0;
        it.status = st;
        expected_listing.push_back(it);
      end
    end
  endtask

  task automatic send_item(req_e req, data_t val);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    predict_listing(req, val);
    requests_sent++;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
  endtask

  task automatic drain_results;
    in_valid_i <= 1'b0;
    wait (expected_listing.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return data_t'(32'h8000_0000);
          1: return data_t'(32'h7FFF_FFFF);
          2: return data_t'(32'hFFFF_FFFF);
          default: return '0;
        endcase
      end
      1, 2, 3: return data_t'($urandom_range(16)) - data_t'(8);
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic send_random(int ins_pct);
    req_e  req;
    data_t val;
    req = ($urandom_range(99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
    val = pick_value();
    if (req == REQ_REMOVE && shadow_count > 0 && $urandom_range(3) != 0)
      val = shadow_list[$urandom_range(shadow_count - 1)];
    send_item(req, val);
  endtask

  task automatic run_random(int n, int snd_pct, int rcv_pct, int ins_pct);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    repeat (n) send_random(ins_pct);
    drain_results();
  endtask

  task automatic test_directed;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    send_item(REQ_REMOVE, data_t'(5));
    send_item(REQ_INSERT, data_t'(0));
    send_item(REQ_REMOVE, data_t'(7));
    send_item(REQ_REMOVE, data_t'(0));
    send_item(REQ_INSERT, data_t'(32'h7FFF_FFFF));
    send_item(REQ_INSERT, data_t'(32'h8000_0000));
    send_item(REQ_INSERT, data_t'(32'hFFFF_FFFF));
    send_item(REQ_INSERT, data_t'(32'hFFFF_FFFF));
    send_item(REQ_INSERT, data_t'(0));
    send_item(REQ_INSERT, data_t'(1));
    send_item(REQ_INSERT, data_t'(32'h5555_5555));
    send_item(REQ_INSERT, data_t'(32'hAAAA_AAAA));
    send_item(REQ_INSERT, data_t'(2));
    send_item(REQ_INSERT, data_t'(-2));
    send_item(REQ_INSERT, data_t'(100));
    send_item(REQ_INSERT, data_t'(-100));
    send_item(REQ_INSERT, data_t'(7));
    send_item(REQ_INSERT, data_t'(7));
    send_item(REQ_INSERT, data_t'(32'h0000_FFFF));
    send_item(REQ_INSERT, data_t'(32'hFFFF_0000));
    send_item(REQ_INSERT, data_t'(3));
    send_item(REQ_REMOVE, data_t'(32'h8000_0000));
    send_item(REQ_REMOVE, data_t'(32'h7FFF_FFFF));
    send_item(REQ_REMOVE, data_t'(32'hFFFF_FFFF));
    send_item(REQ_REMOVE, data_t'(12345));
    drain_results();
  endtask

  task automatic test_no_idle;
    run_random(30, 0, 0, 60);
  endtask

  task automatic test_sender_idle;
    run_random(30, 88, 0, 70);
  endtask

  task automatic test_receiver_stall;
    run_random(30, 0, 88, 40);
  endtask

  task automatic test_both_idle;
    run_random(20, 6, 6, 60);
  endtask

  task automatic test_holdoff;
    holdoff_cycles = HOLDOFF_LEN;
    run_random(12, 0, 0, 70);
  endtask

  task automatic test_pause;
    run_random(4, 0, 0, 50);
    run_random(4, 0, 0, 50);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_listing.size() == 0) begin
          report_mismatch("unexpected item", item_value_o, '0);
        end else begin
          head_item = expected_listing.pop_front();
          items_checked++;
          if (item_value_o !== head_item.value)
            report_mismatch("item_value", item_value_o, head_item.value);
          if (is_last_o !== head_item.last)
            report_mismatch("is_last", 32'(is_last_o), 32'(head_item.last));
          if (is_empty_o !== head_item.empty)
            report_mismatch("is_empty", 32'(is_empty_o), 32'(head_item.empty));
          if (status_o !== head_item.status)
            report_mismatch("status", 32'(status_o), 32'(head_item.status));
        end
      end
      if (holdoff_cycles > 0) begin
        out_stall_i <= 1'b1;
        holdoff_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_holdoff();
    test_pause();
    $display("%0d requests, %0d listed items checked, longest list %0d of %0d",
             requests_sent, items_checked, peak_count, CAPACITY);
    $display("outcomes: ok %0d, not found %0d, full %0d, remove on empty %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/slir_pkg.sv
rtl/slir_store.sv
rtl/slir_ctrl.sv
rtl/slir_out.sv
rtl/sorted_list_insert_remove.sv
verif/tb_sorted_list_insert_remove.sv
